FILE: src/slc_pkg.sv
// Shared constants and types for the soft limiter clipper.
package slc_pkg;

    // Block geometry.
    localparam int BLOCK_SIZE = 64;
    localparam int IDX_W      = $clog2(BLOCK_SIZE);
    localparam int CNT_W      = $clog2(BLOCK_SIZE + 1);
    localparam int RAM_DEPTH  = 2 * (1 << IDX_W);
    localparam int RAM_AW     = IDX_W + 1;

    // Arithmetic widths.
    localparam int SMP_W   = 16;
    localparam int SQ_W    = 32;
    localparam int SUM_W   = 38;
    localparam int RAD_W   = 48;
    localparam int ROOT_W  = 24;
    localparam int RATIO_W = 16;
    localparam int PROD_W  = RATIO_W + ROOT_W;
    localparam int THR_W   = 28;
    localparam int NUM_W   = SMP_W + THR_W;
    localparam int QUO_W   = 17;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd6144;

    // Block descriptor queue.
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    // One finished block waiting for the back end.
    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] n;
        logic [SUM_W-1:0] sum;
    } desc_t;

endpackage

FILE: src/slc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module slc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/slc_fifo.sv
// Short queue of finished block descriptors between front and back end.
module slc_fifo import slc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  desc_t             push_desc,
    input  logic              pop,
    output desc_t             head,
    output logic [FCNT_W-1:0] count
);

    desc_t             slot_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wptr_reg;
    logic [PTR_W-1:0]  rptr_reg;
    logic [FCNT_W-1:0] count_reg;

    assign head  = slot_reg[rptr_reg];
    assign count = count_reg;

    // Pointers and fill count; the back end pops only a nonempty queue.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= push_desc;
        end
    end

endmodule

FILE: src/slc_front.sv
// Front end: accepts samples, stores them and sums their power per block.
module slc_front import slc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,
    input  logic              s_tlast,
    output logic              wr_en,
    output logic [RAM_AW-1:0] wr_addr,
    output logic [31:0]       wr_data,
    output logic              push,
    output desc_t             push_desc,
    input  logic [FCNT_W-1:0] fifo_cnt
);

    logic             bank_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] sum_reg;
    logic             p_valid_reg;
    logic             p_end_reg;
    logic             p_bank_reg;
    logic [CNT_W-1:0] p_n_reg;
    logic [SQ_W-1:0]  p_sq_reg;

    logic              accept;
    logic [CNT_W-1:0]  n_new;
    logic              blk_end;
    logic signed [31:0] pi;
    logic signed [31:0] pq;
    logic [SQ_W-1:0]   sq;
    logic [SUM_W-1:0]  sum_next;
    logic [FCNT_W:0]   pending;

    // Space for a new block exists while fewer than two are outstanding.
    assign pending  = {1'b0, fifo_cnt} + (FCNT_W + 1)'(p_valid_reg && p_end_reg);
    assign s_tready = pending < (FCNT_W + 1)'(FIFO_DEPTH);
    assign accept   = s_tvalid && s_tready;

    // Block boundary: marked last, or the block is full.
    assign n_new   = cnt_reg + 1'b1;
    assign blk_end = s_tlast || (n_new == CNT_W'(BLOCK_SIZE));

    // Store the item into the current bank.
    assign wr_en   = accept;
    assign wr_addr = {bank_reg, cnt_reg[IDX_W-1:0]};
    assign wr_data = s_tdata;

    // Power of the incoming item.
    assign pi = $signed(s_tdata[15:0]) * $signed(s_tdata[15:0]);
    assign pq = $signed(s_tdata[31:16]) * $signed(s_tdata[31:16]);
    assign sq = SQ_W'(pi) + SQ_W'(pq);

    // Accumulate in the cycle after each item is taken and hand the finished block to the queue.
    assign sum_next = sum_reg + SUM_W'(p_sq_reg);
    assign push     = p_valid_reg && p_end_reg;
    always_comb begin
        push_desc.bank = p_bank_reg;
        push_desc.n    = p_n_reg;
        push_desc.sum  = sum_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_reg    <= 1'b0;
            cnt_reg     <= '0;
            sum_reg     <= '0;
            p_valid_reg <= 1'b0;
            p_end_reg   <= 1'b0;
        end else begin
            p_valid_reg <= accept;
            if (accept) begin
                p_end_reg  <= blk_end;
                p_bank_reg <= bank_reg;
                p_n_reg    <= n_new;
                p_sq_reg   <= sq;
                if (blk_end) begin
                    cnt_reg  <= '0;
                    bank_reg <= !bank_reg;
                end else begin
                    cnt_reg <= n_new;
                end
            end
            if (p_valid_reg) begin
                sum_reg <= p_end_reg ? '0 : sum_next;
            end
        end
    end

endmodule

FILE: src/slc_isqrt.sv
// Iterative integer square root, one result bit per cycle.
module slc_isqrt import slc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic [ROOT_W-1:0] root,
    output logic              done
);

    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W+1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [4:0]        step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;
    logic              fits;

    assign rem_sh = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign fits   = rem_sh >= trial;
    assign root   = root_reg;
    assign done   = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            // Done pulses for one cycle after the last root bit.
            done_reg <= busy_reg && !start && (step_reg == '0);
            if (start) begin
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                step_reg <= 5'(ROOT_W - 1);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                // Try the next root bit against the partial remainder.
                rad_reg  <= rad_reg << 2;
                rem_reg  <= fits ? rem_sh - trial : rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], fits};
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

FILE: src/slc_back.sv
// Back end: forms the block threshold and emits each sample, clipped if needed.
module slc_back import slc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [RATIO_W-1:0] ratio,
    input  desc_t              head,
    input  logic [FCNT_W-1:0]  fifo_cnt,
    output logic               pop,
    output logic [RAM_AW-1:0]  rd_addr,
    input  logic [31:0]        rd_data,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,
    output logic               m_tuser,
    output logic               m_tlast
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MEAN, ST_RMS_GO, ST_RMS, ST_THR_MUL, ST_THR_RND, ST_THR_SQ,
        ST_RD, ST_LOAD, ST_CMP, ST_MAG, ST_MUL, ST_DIV, ST_FIN, ST_EMIT
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       n_reg;
    logic                   bank_reg;
    logic [CNT_W-1:0]       k_reg;
    logic [5:0]             step_reg;
    logic [SUM_W-1:0]       mdiv_reg;
    logic [CNT_W-1:0]       mrem_reg;
    logic [ROOT_W-1:0]      rms_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [THR_W-1:0]       thr_reg;
    logic [2*THR_W-1:0]     thr2_reg;
    logic signed [SMP_W-1:0] vi_reg;
    logic signed [SMP_W-1:0] vq_reg;
    logic [SQ_W-1:0]        mag2_reg;
    logic [ROOT_W-1:0]      mag8_reg;
    logic [ROOT_W-1:0]      remi_reg;
    logic [ROOT_W-1:0]      remq_reg;
    logic [QUO_W-1:0]       dqi_reg;
    logic [QUO_W-1:0]       dqq_reg;
    logic [SMP_W-1:0]       res_i_reg;
    logic [SMP_W-1:0]       res_q_reg;
    logic                   res_clip_reg;
    logic                   m_tvalid_reg;
    logic [31:0]            m_tdata_reg;
    logic                   m_tuser_reg;
    logic                   m_tlast_reg;

    logic                   sqrt_start;
    logic [RAD_W-1:0]       sqrt_rad;
    logic [ROOT_W-1:0]      sqrt_root;
    logic                   sqrt_done;
    logic [CNT_W:0]         mt;
    logic                   mfit;
    logic [PROD_W:0]        thr_sum;
    logic signed [31:0]     pi;
    logic signed [31:0]     pq;
    logic                   clip;
    logic [SMP_W-1:0]       abs_i;
    logic [SMP_W-1:0]       abs_q;
    logic [NUM_W-1:0]       num_i;
    logic [NUM_W-1:0]       num_q;
    logic [ROOT_W:0]        ti;
    logic [ROOT_W:0]        tq;
    logic                   fit_i;
    logic                   fit_q;
    logic                   out_free;
    logic                   is_last;

    // Round the quotient to nearest, apply the sign and saturate.
    function automatic logic [SMP_W-1:0] finish(
        input logic              neg,
        input logic [QUO_W-1:0]  quo,
        input logic [ROOT_W-1:0] rem,
        input logic [ROOT_W-1:0] div
    );
        logic [QUO_W:0] q;
        q = {1'b0, quo} + (QUO_W + 1)'({rem, 1'b0} >= {1'b0, div});
        if (neg) begin
            finish = (q > (QUO_W + 1)'(32768)) ? 16'h8000 : SMP_W'(-q);
        end else begin
            finish = (q > (QUO_W + 1)'(32767)) ? 16'h7fff : SMP_W'(q);
        end
    endfunction

    slc_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sqrt_rad),
        .root     (sqrt_root),
        .done     (sqrt_done)
    );

    // The root unit serves both the block RMS and each sample magnitude.
    assign sqrt_start = (state_reg == ST_RMS_GO) || ((state_reg == ST_CMP) && clip);
    assign sqrt_rad   = (state_reg == ST_RMS_GO) ? {mdiv_reg[SQ_W-1:0], 16'b0}
                                                 : {mag2_reg, 16'b0};

    // Mean power divider step.
    assign mt   = {mrem_reg, mdiv_reg[SUM_W-1]};
    assign mfit = mt >= {1'b0, n_reg};

    // Threshold rounding.
    assign thr_sum = {1'b0, prod_reg} + (PROD_W + 1)'(2048);

    // Sample power and clip decision.
    assign pi   = $signed(rd_data[15:0]) * $signed(rd_data[15:0]);
    assign pq   = $signed(rd_data[31:16]) * $signed(rd_data[31:16]);
    assign clip = {8'b0, mag2_reg, 16'b0} > thr2_reg;

    // Scaled numerators.
    assign abs_i = vi_reg[SMP_W-1] ? SMP_W'(-vi_reg) : SMP_W'(vi_reg);
    assign abs_q = vq_reg[SMP_W-1] ? SMP_W'(-vq_reg) : SMP_W'(vq_reg);
    assign num_i = abs_i * thr_reg;
    assign num_q = abs_q * thr_reg;

    // Quotient divider steps, I and Q side by side.
    assign ti    = {remi_reg, dqi_reg[QUO_W-1]};
    assign tq    = {remq_reg, dqq_reg[QUO_W-1]};
    assign fit_i = ti >= {1'b0, mag8_reg};
    assign fit_q = tq >= {1'b0, mag8_reg};

    assign out_free = !m_tvalid_reg || m_tready;
    assign is_last  = (k_reg + 1'b1) == n_reg;
    assign pop      = (state_reg == ST_EMIT) && out_free && is_last;
    assign rd_addr  = {bank_reg, k_reg[IDX_W-1:0]};

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // Sequencer with its datapath and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            // The output register loads in the emit state and drains on ready.
            if ((state_reg == ST_EMIT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (fifo_cnt != '0) begin
                        n_reg     <= head.n;
                        bank_reg  <= head.bank;
                        mdiv_reg  <= head.sum;
                        mrem_reg  <= '0;
                        step_reg  <= 6'(SUM_W - 1);
                        state_reg <= ST_MEAN;
                    end
                end
                ST_MEAN: begin
                    mrem_reg <= mfit ? CNT_W'(mt - {1'b0, n_reg}) : mt[CNT_W-1:0];
                    mdiv_reg <= {mdiv_reg[SUM_W-2:0], mfit};
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == '0) begin
                        state_reg <= ST_RMS_GO;
                    end
                end
                ST_RMS_GO: begin
                    state_reg <= ST_RMS;
                end
                ST_RMS: begin
                    if (sqrt_done) begin
                        rms_reg   <= sqrt_root;
                        state_reg <= ST_THR_MUL;
                    end
                end
                ST_THR_MUL: begin
                    prod_reg  <= ratio * rms_reg;
                    state_reg <= ST_THR_RND;
                end
                ST_THR_RND: begin
                    thr_reg   <= thr_sum[12 +: THR_W];
                    state_reg <= ST_THR_SQ;
                end
                ST_THR_SQ: begin
                    thr2_reg  <= thr_reg * thr_reg;
                    k_reg     <= '0;
                    state_reg <= ST_RD;
                end
                ST_RD: begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    vi_reg    <= $signed(rd_data[15:0]);
                    vq_reg    <= $signed(rd_data[31:16]);
                    mag2_reg  <= SQ_W'(pi) + SQ_W'(pq);
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    if (clip) begin
                        state_reg <= ST_MAG;
                    end else begin
                        res_i_reg    <= vi_reg;
                        res_q_reg    <= vq_reg;
                        res_clip_reg <= 1'b0;
                        state_reg    <= ST_EMIT;
                    end
                end
                ST_MAG: begin
                    if (sqrt_done) begin
                        mag8_reg  <= sqrt_root;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    // Quotient is known to fit, so the high part starts below the divisor.
                    remi_reg  <= num_i[QUO_W +: ROOT_W];
                    dqi_reg   <= num_i[QUO_W-1:0];
                    remq_reg  <= num_q[QUO_W +: ROOT_W];
                    dqq_reg   <= num_q[QUO_W-1:0];
                    step_reg  <= 6'(QUO_W - 1);
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    remi_reg <= fit_i ? ROOT_W'(ti - {1'b0, mag8_reg}) : ti[ROOT_W-1:0];
                    dqi_reg  <= {dqi_reg[QUO_W-2:0], fit_i};
                    remq_reg <= fit_q ? ROOT_W'(tq - {1'b0, mag8_reg}) : tq[ROOT_W-1:0];
                    dqq_reg  <= {dqq_reg[QUO_W-2:0], fit_q};
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == '0) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    res_i_reg    <= finish(vi_reg[SMP_W-1], dqi_reg, remi_reg, mag8_reg);
                    res_q_reg    <= finish(vq_reg[SMP_W-1], dqq_reg, remq_reg, mag8_reg);
                    res_clip_reg <= 1'b1;
                    state_reg    <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_tdata_reg  <= {res_q_reg, res_i_reg};
                        m_tuser_reg  <= res_clip_reg;
                        m_tlast_reg  <= is_last;
                        if (is_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= ST_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: src/soft_limiter_clipper_unit.sv
// Top level of the block soft limiter (amplitude clipper).
//
//  Channel   Direction  Handshake          Contents
//  s_        in         s_tvalid/s_tready  one complex sample, s_tlast ends a block
//  m_        out        m_tvalid/m_tready  one clipped sample, m_tlast ends a block
//  cfg_      in         cfg_wr_en          clipping ratio, unsigned Q4.12
//
// The front end takes one item per cycle while the descriptor queue has room.
// Per block the back end first forms the threshold (38 mean-divider steps and 24
// root steps), then emits each item; a clipped item also passes the shared root
// unit (24 steps) and the quotient divider (17 steps), an unclipped item neither.
// Reset is synchronous and active low; the sample RAM is not cleared.
// Input stalls only when two blocks are outstanding; output stalls hold the back end.
module soft_limiter_clipper_unit import slc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,   // sample_i [15:0], sample_q [31:16]
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,   // clipped_i [15:0], clipped_q [31:16]
    output logic               m_tuser,   // was_clipped [0]
    output logic               m_tlast,
    input  logic               cfg_wr_en,
    input  logic [RATIO_W-1:0] cfg_wr_data
);

    logic [RATIO_W-1:0] ratio_reg;
    logic               wr_en;
    logic [RAM_AW-1:0]  wr_addr;
    logic [31:0]        wr_data;
    logic [RAM_AW-1:0]  rd_addr;
    logic [31:0]        rd_data;
    logic               push;
    desc_t              push_desc;
    logic               pop;
    desc_t              head;
    logic [FCNT_W-1:0]  fifo_cnt;

    // Clipping ratio register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg <= RATIO_RESET;
        end else if (cfg_wr_en) begin
            ratio_reg <= cfg_wr_data;
        end
    end

    slc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .push      (push),
        .push_desc (push_desc),
        .fifo_cnt  (fifo_cnt)
    );

    slc_ram #(
        .WIDTH (32),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    slc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .count     (fifo_cnt)
    );

    slc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ratio    (ratio_reg),
        .head     (head),
        .fifo_cnt (fifo_cnt),
        .pop      (pop),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: src/slc_checker.sv
// Port-level checks for the soft limiter clipper, bound to the top level.
module slc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    logic [8:0] outstanding_reg;
    logic       s_acc;
    logic       m_acc;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    // Items taken in but not yet delivered.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outstanding_reg <= '0;
        end else if (s_acc && !m_acc) begin
            outstanding_reg <= outstanding_reg + 1'b1;
        end else if (m_acc && !s_acc) begin
            outstanding_reg <= outstanding_reg - 1'b1;
        end
    end

    // A result never appears without an item behind it.
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> outstanding_reg != '0)
        else $error("result shown with no item outstanding");

    // Reset leaves the queue empty, so input is ready right after.
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("not ready or result shown after reset");

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    a_data_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

endmodule

bind soft_limiter_clipper_unit slc_checker u_slc_checker (.*);
